/* rtl/sle_pkg.sv */
// Shared types and codes for the sorted list engine.
// Holds the request and response beat structs, opcode and status codes, and the sequencer
// states. No dependencies.
package sle_pkg;

   localparam int CAPACITY = 32;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_LIST   = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] item_value;
      logic [5:0]         position;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_DEL_RD,
      ST_DEL_CMP,
      ST_LS_RD,
      ST_LS_OUT
   } state_type;

endpackage

/* rtl/sle_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sorted_list_engine.sv */
// Sorted list engine top level: sequencer, compare logic and entry RAM.
// Depends on sle_pkg and sle_ram.
//
// Usage:
//   req channel carries one operation per beat: insert, delete first equal, or list.
//   rsp channel returns one status beat per insert or delete, and one beat per stored
//   entry for a list (ascending, 1-based position, last set on the final beat). A list
//   of an empty store returns a single empty beat. An unused kind is dropped.
//   Entries live in a RAM with registered read; the sequencer walks it one entry at a
//   time, reading each entry before it compares or sends it.
//   Insert walks down from the top, moving each entry not below the new value up one
//   slot, and writes the new value above the first smaller entry. Delete scans every
//   entry and shifts those after the first match down. List reads and sends each entry
//   in turn.
//   A full insert, an empty delete or an empty list answers with no RAM access.
//   req_ready is high only while the sequencer is idle; one operation is in work at a time.
//   rsp holds in an output register; a stalled receiver freezes the sequencer at its
//   next beat while the store and the beat in flight hold.
//   Reset clears the entry count; the RAM needs no clearing pass.
module sorted_list_engine #(
   parameter int CAPACITY = sle_pkg::CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sle_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 6) ? CW : 6;

   sle_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic               found_ff, found_in;
   logic signed [31:0] value_ff, value_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sle_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        rd_data;
   logic signed [31:0] entry;
   logic               slot_free;
   logic               scan_last;
   logic               found_now;
   logic [PW-1:0]      pos_wide;

   sle_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign entry     = $signed(rd_data);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign scan_last = (scan_ff + CW'(1)) == count_ff;
   assign found_now = found_ff || (entry == value_ff);
   assign pos_wide  = PW'(scan_ff) + PW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      ptr_ff      <= ptr_in;
      found_ff    <= found_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      ptr_in       = ptr_ff;
      found_in     = found_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = value_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_ff[AW-1:0];
      req_ready    = 1'b0;

      unique case (state_ff)
         sle_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               value_in = req_data.value;
               scan_in  = '0;
               found_in = 1'b0;
               ptr_in   = count_ff[AW-1:0];
               case (req_data.kind)
                  sle_pkg::KIND_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = sle_pkg::STATUS_FULL;
                        state_in  = sle_pkg::ST_LS_OUT;
                     end else if (count_ff == '0) begin
                        state_in = sle_pkg::ST_INS_PUT;
                     end else begin
                        state_in = sle_pkg::ST_INS_RD;
                     end
                  end
                  sle_pkg::KIND_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = sle_pkg::STATUS_EMPTY;
                        state_in  = sle_pkg::ST_LS_OUT;
                     end else begin
                        state_in = sle_pkg::ST_DEL_RD;
                     end
                  end
                  sle_pkg::KIND_LIST: begin
                     if (count_ff == '0) begin
                        status_in = sle_pkg::STATUS_EMPTY;
                        state_in  = sle_pkg::ST_LS_OUT;
                     end else begin
                        status_in = sle_pkg::STATUS_OK;
                        state_in  = sle_pkg::ST_LS_RD;
                     end
                  end
                  default: state_in = sle_pkg::ST_IDLE;
               endcase
               found_in = (req_data.kind == sle_pkg::KIND_LIST) && (count_ff != '0);
            end
         end
         sle_pkg::ST_INS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_ff - AW'(1);
            state_in = sle_pkg::ST_INS_CMP;
         end
         sle_pkg::ST_INS_CMP: begin
            wr_en = 1'b1;
            if (entry >= value_ff) begin
               wr_data  = rd_data;
               ptr_in   = ptr_ff - AW'(1);
               state_in = (ptr_ff == AW'(1)) ? sle_pkg::ST_INS_PUT : sle_pkg::ST_INS_RD;
            end else begin
               count_in  = count_ff + CW'(1);
               status_in = sle_pkg::STATUS_OK;
               state_in  = sle_pkg::ST_LS_OUT;
            end
         end
         sle_pkg::ST_INS_PUT: begin
            wr_en     = 1'b1;
            count_in  = count_ff + CW'(1);
            status_in = sle_pkg::STATUS_OK;
            state_in  = sle_pkg::ST_LS_OUT;
         end
         sle_pkg::ST_DEL_RD: begin
            rd_en    = 1'b1;
            state_in = sle_pkg::ST_DEL_CMP;
         end
         sle_pkg::ST_DEL_CMP: begin
            // shift down every entry after the match
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = scan_ff[AW-1:0] - AW'(1);
               wr_data = rd_data;
            end
            found_in = found_now;
            scan_in  = scan_ff + CW'(1);
            if (scan_last) begin
               if (found_now) begin
                  count_in  = count_ff - CW'(1);
                  status_in = sle_pkg::STATUS_OK;
               end else begin
                  status_in = sle_pkg::STATUS_NOT_FOUND;
               end
               found_in = 1'b0;
               state_in = sle_pkg::ST_LS_OUT;
            end else begin
               state_in = sle_pkg::ST_DEL_RD;
            end
         end
         sle_pkg::ST_LS_RD: begin
            rd_en    = 1'b1;
            state_in = sle_pkg::ST_LS_OUT;
         end
         sle_pkg::ST_LS_OUT: begin
            // found_ff marks a listing beat; otherwise a single status beat
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  rsp_data_in.status     = sle_pkg::STATUS_OK;
                  rsp_data_in.item_value = entry;
                  rsp_data_in.position   = pos_wide[5:0];
                  rsp_data_in.last       = scan_last;
                  scan_in                = scan_ff + CW'(1);
                  state_in = scan_last ? sle_pkg::ST_IDLE : sle_pkg::ST_LS_RD;
               end else begin
                  rsp_data_in.status     = status_ff;
                  rsp_data_in.item_value = '0;
                  rsp_data_in.position   = '0;
                  rsp_data_in.last       = 1'b1;
                  state_in               = sle_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sle_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == $past(count_ff) + CW'(1)
                              || count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sle_pkg::ST_INS_RD || state_ff == sle_pkg::ST_INS_PUT)
      |-> count_ff < CW'(CAPACITY))
      else $error("insert in progress on a full store");

   a_list_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sle_pkg::ST_LS_OUT && found_ff) |-> scan_ff < count_ff)
      else $error("listing beyond stored entries");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for sorted_list_engine: a directed table of beats, then random
// insert, delete and list traffic, each result checked against a shadow sorted store.
// Depends on sle_pkg and the sorted_list_engine RTL.
module testbench;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int DIRECTED_ROWS = 22;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic               typed;
      logic [1:0]         status;
   } row_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sle_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sle_pkg::rsp_type rsp_data;

   logic signed [31:0] shadow_entries [sle_pkg::CAPACITY];
   int                 shadow_count = 0;
   sle_pkg::rsp_type   due_rsp [$];
   int                 mismatches = 0;
   int                 idle_pct = 14;
   int                 stall_pct = 14;
   row_type            directed [DIRECTED_ROWS];

   sorted_list_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("sorted_list_engine test failed");
      $finish;
   end

   function automatic void store_apply(input sle_pkg::req_type beat);
      int               slot;
      sle_pkg::rsp_type r;
      r = '0;
      r.last = 1'b1;
      case (beat.kind)
         sle_pkg::KIND_INSERT: begin
            if (shadow_count >= sle_pkg::CAPACITY) begin
               r.status = sle_pkg::STATUS_FULL;
            end else begin
               slot = 0;
               while (slot < shadow_count &&
                      $signed(shadow_entries[slot]) < $signed(beat.value)) slot++;
               for (int j = shadow_count; j > slot; j--) shadow_entries[j] = shadow_entries[j - 1];
               shadow_entries[slot] = beat.value;
               shadow_count++;
            end
            due_rsp.push_back(r);
         end
         sle_pkg::KIND_DELETE: begin
            if (shadow_count == 0) begin
               r.status = sle_pkg::STATUS_EMPTY;
            end else begin
               slot = 0;
               while (slot < shadow_count && shadow_entries[slot] != beat.value) slot++;
               if (slot == shadow_count) begin
                  r.status = sle_pkg::STATUS_NOT_FOUND;
               end else begin
                  for (int j = slot; j < shadow_count - 1; j++)
                     shadow_entries[j] = shadow_entries[j + 1];
                  shadow_count--;
               end
            end
            due_rsp.push_back(r);
         end
         sle_pkg::KIND_LIST: begin
            if (shadow_count == 0) begin
               r.status = sle_pkg::STATUS_EMPTY;
               due_rsp.push_back(r);
            end else begin
               for (int j = 0; j < shadow_count; j++) begin
                  r.item_value = shadow_entries[j];
                  r.position   = 6'(j + 1);
                  r.last       = (j == shadow_count - 1);
                  due_rsp.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_beat(input sle_pkg::req_type beat, input logic typed,
                            input logic [1:0] status);
      sle_pkg::rsp_type fixed;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      store_apply(beat);
      if (typed) begin
         fixed = '0;
         fixed.status = status;
         fixed.last = 1'b1;
         void'(due_rsp.pop_back());
         due_rsp.push_back(fixed);
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(3))
         0: return $signed($urandom_range(8)) - 4;
         1: begin
            case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return -32'sd1;
               default: return 32'sd0;
            endcase
         end
         2: begin
            if (shadow_count > 0) return shadow_entries[$urandom_range(shadow_count - 1)];
            return $urandom();
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic send_mixed();
      sle_pkg::req_type beat;
      int               roll;
      roll = $urandom_range(99);
      beat.value = pick_value();
      if (roll < 45) begin
         beat.kind = sle_pkg::KIND_INSERT;
      end else if (roll < 80) begin
         beat.kind = sle_pkg::KIND_DELETE;
         if (shadow_count > 0 && $urandom_range(3) != 0)
            beat.value = shadow_entries[$urandom_range(shadow_count - 1)];
      end else if (roll < 95) begin
         beat.kind = sle_pkg::KIND_LIST;
      end else begin
         beat.kind = KIND_UNUSED;
      end
      send_beat(beat, 1'b0, sle_pkg::STATUS_OK);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      sle_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp.size() == 0) begin
            $display("%0t unexpected beat: expected none actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = due_rsp.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("item_value", want.item_value, rsp_data.item_value);
            check_field("position", 32'(want.position), 32'(rsp_data.position));
            check_field("last", 32'(want.last), 32'(rsp_data.last));
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      sle_pkg::req_type beat;
      directed = '{
         '{sle_pkg::KIND_LIST,   32'sd0,         1'b1, sle_pkg::STATUS_EMPTY},
         '{sle_pkg::KIND_DELETE, 32'sd5,         1'b1, sle_pkg::STATUS_EMPTY},
         '{KIND_UNUSED,          32'sh7fff_ffff, 1'b0, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_INSERT, 32'sh7fff_ffff, 1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_INSERT, 32'sh8000_0000, 1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_INSERT, 32'sd0,         1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_INSERT, -32'sd1,        1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_INSERT, 32'sd0,         1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_INSERT, 32'sd1,         1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_LIST,   32'sh5a5a_5a5a, 1'b0, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_DELETE, 32'sd12345,     1'b1, sle_pkg::STATUS_NOT_FOUND},
         '{sle_pkg::KIND_DELETE, 32'sd0,         1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_DELETE, 32'sh8000_0000, 1'b1, sle_pkg::STATUS_OK},
         '{KIND_UNUSED,          32'sd0,         1'b0, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_LIST,   -32'sd1,        1'b0, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_DELETE, 32'sh7fff_ffff, 1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_DELETE, 32'sh7fff_ffff, 1'b1, sle_pkg::STATUS_NOT_FOUND},
         '{sle_pkg::KIND_DELETE, -32'sd1,        1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_DELETE, 32'sd0,         1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_DELETE, 32'sd1,         1'b1, sle_pkg::STATUS_OK},
         '{sle_pkg::KIND_DELETE, 32'sd1,         1'b1, sle_pkg::STATUS_EMPTY},
         '{sle_pkg::KIND_LIST,   32'sd0,         1'b1, sle_pkg::STATUS_EMPTY}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         beat.kind  = directed[i].kind;
         beat.value = directed[i].value;
         send_beat(beat, directed[i].typed, directed[i].status);
      end

      repeat (20) send_mixed();

      // fill to capacity, overflow, then drain with no idling on either side
      idle_pct  = 0;
      stall_pct = 0;
      while (shadow_count < sle_pkg::CAPACITY) begin
         beat.kind  = sle_pkg::KIND_INSERT;
         beat.value = pick_value();
         send_beat(beat, 1'b0, sle_pkg::STATUS_OK);
      end
      beat.kind = sle_pkg::KIND_INSERT;
      beat.value = $urandom();
      send_beat(beat, 1'b1, sle_pkg::STATUS_FULL);
      beat.value = 32'sh8000_0000;
      send_beat(beat, 1'b1, sle_pkg::STATUS_FULL);
      beat.kind = sle_pkg::KIND_LIST;
      send_beat(beat, 1'b0, sle_pkg::STATUS_OK);
      for (int n = 0; shadow_count > 0; n++) begin
         beat.kind = sle_pkg::KIND_DELETE;
         if ($urandom_range(5) == 0) beat.value = $urandom();
         else beat.value = shadow_entries[$urandom_range(shadow_count - 1)];
         send_beat(beat, 1'b0, sle_pkg::STATUS_OK);
         if (n % 8 == 7) begin
            beat.kind = sle_pkg::KIND_LIST;
            send_beat(beat, 1'b0, sle_pkg::STATUS_OK);
         end
      end

      idle_pct  = 14;
      stall_pct = 14;
      repeat (10) send_mixed();
      beat.kind = sle_pkg::KIND_LIST;
      send_beat(beat, 1'b0, sle_pkg::STATUS_OK);

      req_valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("sorted_list_engine test passed");
      else $display("sorted_list_engine test failed");
      $finish;
   end

endmodule
